@@ sv/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the control change scanner.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int ANALOG_COUNT  = 8;
  localparam int DIGITAL_COUNT = 32;

  localparam int IDX_W  = 5;
  localparam int AIDX_W = (ANALOG_COUNT > 1) ? $clog2(ANALOG_COUNT) : 1;
  localparam int DIDX_W = (DIGITAL_COUNT > 1) ? $clog2(DIGITAL_COUNT) : 1;

  localparam int SAMPLE_W   = 10;
  localparam int NUM_W      = 7;
  localparam int VAL_W      = 7;
  localparam int CHAN_W     = 5;
  localparam int DEBOUNCE_W = 16;
  localparam int TIME_W     = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 1'd1;

  localparam logic [CHAN_W-1:0]     CHANNEL_RESET  = 5'd1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;

  localparam int              ANALOG_DROP_BITS = 3;
  localparam logic [VAL_W-1:0] FULL_VALUE      = 7'd127;

  localparam logic KIND_ANALOG  = 1'b0;
  localparam logic KIND_DIGITAL = 1'b1;

  typedef enum logic [1:0] {
    MSG_CC       = 2'd0,
    MSG_NOTE_ON  = 2'd1,
    MSG_NOTE_OFF = 2'd2
  } msg_kind_t;

  typedef struct packed {
    logic                input_kind;
    logic [IDX_W-1:0]    input_index;
    logic [SAMPLE_W-1:0] sample;
    logic [NUM_W-1:0]    controller_number;
    logic                digital_style;
    logic [TIME_W-1:0]   now_ms;
  } sample_t;

  typedef struct packed {
    msg_kind_t         message_kind;
    logic [CHAN_W-1:0] channel;
    logic [NUM_W-1:0]  number;
    logic [VAL_W-1:0]  value;
  } message_t;

endpackage

@@ sv/ccs_sample_if.sv @@
// ----------------------------------------------------------------------------
// ccs_sample_if
// Valid/ready channel carrying one scanned control sample per request.
// ----------------------------------------------------------------------------
interface ccs_sample_if import ccs_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ccs_message_if.sv @@
// ----------------------------------------------------------------------------
// ccs_message_if
// Valid/ready channel carrying one outgoing control message per request.
// ----------------------------------------------------------------------------
interface ccs_message_if import ccs_pkg::*; ();
  logic     valid;
  logic     ready;
  message_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/ccs_scan_core.sv @@
// ----------------------------------------------------------------------------
// ccs_scan_core
// Per-control state (last analog value, last level, last edge time) and the
// compare logic that decides whether a sample produces a message.
// ----------------------------------------------------------------------------
module ccs_scan_core import ccs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  sample_t               item,
  input  logic [CHAN_W-1:0]     midi_channel,
  input  logic [DEBOUNCE_W-1:0] debounce_ms,
  output logic                  emit,
  output message_t              msg
);

  logic [VAL_W-1:0]  analog_last [ANALOG_COUNT];
  logic [DIGITAL_COUNT-1:0] digital_last;
  logic [DIGITAL_COUNT-1:0] edge_valid;
  logic [TIME_W-1:0] edge_time [DIGITAL_COUNT];

  logic [AIDX_W-1:0] aidx;
  logic [DIDX_W-1:0] didx;
  logic              analog_in_range;
  logic              digital_in_range;
  logic [VAL_W-1:0]  analog_val;
  logic              analog_change;
  logic              level;
  logic              level_edge;
  logic [TIME_W-1:0] last_time;
  logic [TIME_W-1:0] elapsed;
  logic              edge_pass;
  logic              analog_emit;
  logic              digital_emit;

  always_comb begin
    aidx = item.input_index[AIDX_W-1:0];
    didx = item.input_index[DIDX_W-1:0];
    analog_in_range  = ({1'b0, item.input_index} < (IDX_W+1)'(ANALOG_COUNT));
    digital_in_range = ({1'b0, item.input_index} < (IDX_W+1)'(DIGITAL_COUNT));

    analog_val    = VAL_W'(item.sample >> ANALOG_DROP_BITS);
    analog_change = (analog_val != analog_last[aidx]);

    level      = item.sample[0];
    level_edge = level ^ digital_last[didx];
    // an index that never saw an accepted edge still has time zero
    last_time  = edge_valid[didx] ? edge_time[didx] : '0;
    elapsed    = item.now_ms - last_time;
    edge_pass  = (elapsed > TIME_W'(debounce_ms));

    analog_emit  = (item.input_kind == KIND_ANALOG) && analog_in_range && analog_change;
    digital_emit = (item.input_kind == KIND_DIGITAL) && digital_in_range &&
                   level_edge && edge_pass;
    emit = analog_emit || digital_emit;

    msg.channel = midi_channel;
    msg.number  = item.controller_number;
    if (item.input_kind == KIND_ANALOG) begin
      msg.message_kind = MSG_CC;
      msg.value        = analog_val;
    end else begin
      msg.value = level ? FULL_VALUE : '0;
      if (item.digital_style) begin
        msg.message_kind = level ? MSG_NOTE_ON : MSG_NOTE_OFF;
      end else begin
        msg.message_kind = MSG_CC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANALOG_COUNT; i++) begin
        analog_last[i] <= '0;
      end
      digital_last <= '0;
      edge_valid   <= '0;
    end else if (fire) begin
      if (analog_emit) begin
        analog_last[aidx] <= analog_val;
      end
      // level follows the input even when the edge is held off
      if (item.input_kind == KIND_DIGITAL && digital_in_range) begin
        digital_last[didx] <= level;
      end
      if (digital_emit) begin
        edge_valid[didx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && digital_emit) begin
      edge_time[didx] <= item.now_ms;
    end
  end

  a_digital_value: assert property (@(posedge clk) disable iff (rst)
    digital_emit |-> (msg.value == FULL_VALUE || msg.value == '0))
    else $error("digital message value is neither full nor zero");

  a_digital_level: assert property (@(posedge clk) disable iff (rst)
    (fire && digital_emit) |=> (digital_last[$past(didx)] == $past(level)))
    else $error("stored level does not follow accepted edge");

  a_edge_time: assert property (@(posedge clk) disable iff (rst)
    (fire && digital_emit) |=> (edge_valid[$past(didx)] &&
                                edge_time[$past(didx)] == $past(item.now_ms)))
    else $error("edge time not recorded");

endmodule

@@ sv/ccs_msg_reg.sv @@
// ----------------------------------------------------------------------------
// ccs_msg_reg
// Output register of the message channel; tells the pipeline when it may
// advance.
// ----------------------------------------------------------------------------
module ccs_msg_reg import ccs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic          emit,
  input  message_t      msg,
  output logic          advance,
  ccs_message_if.source messages
);

  logic     out_valid;
  message_t out_msg;

  assign advance        = !out_valid || messages.ready;
  assign messages.valid = out_valid;
  assign messages.data  = out_msg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (messages.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_msg <= msg;
    end
  end

endmodule

@@ sv/control_change_scanner.sv @@
// ----------------------------------------------------------------------------
// control_change_scanner
// Turns scanned analog and digital control samples into control change and
// note messages, with per-control change detection and edge debounce.
// ----------------------------------------------------------------------------
// A sample request, once accepted, waits in the input register until the output
// register can take its result. Throughput: one sample per cycle; the state compare
// is combinational between the two registers, and only a stalled message holds.
// Reset: synchronous, active high; all per-control state and both config
// registers reset at once, edge times through their valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module control_change_scanner import ccs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ccs_sample_if.sink            samples,
  ccs_message_if.source         messages
);

  logic                  s1_valid;
  sample_t               s1_item;
  logic                  advance;
  logic                  fire;
  logic                  emit;
  message_t              msg;
  logic [CHAN_W-1:0]     midi_channel;
  logic [DEBOUNCE_W-1:0] debounce_ms;

  assign fire          = s1_valid && advance;
  assign samples.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      midi_channel <= CHANNEL_RESET;
      debounce_ms  <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MIDI_CHANNEL: midi_channel <= cfg_data[CHAN_W-1:0];
        CFG_DEBOUNCE:     debounce_ms  <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: hold while the output side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_item <= samples.data;
    end
  end

  ccs_scan_core u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (s1_item),
    .midi_channel (midi_channel),
    .debounce_ms  (debounce_ms),
    .emit         (emit),
    .msg          (msg)
  );

  ccs_msg_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .emit     (emit),
    .msg      (msg),
    .advance  (advance),
    .messages (messages)
  );

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (s1_valid && messages.valid && !messages.ready))
    else $error("input stalled without a stalled message");

  a_silent_item_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && !emit) |=> !messages.valid)
    else $error("message shown for an item that produced none");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    messages.valid |-> (messages.data.message_kind == MSG_CC ||
                        messages.data.message_kind == MSG_NOTE_ON ||
                        messages.data.message_kind == MSG_NOTE_OFF))
    else $error("bad message kind");

endmodule

@@ verif/scanner_checker.sv @@
// ----------------------------------------------------------------------------
// scanner_checker
// Watches the sample and message channels of the control change scanner,
// predicts every outgoing message from its own copy of the per-control state
// and the configuration registers, and compares each message in order.
// ----------------------------------------------------------------------------
module scanner_checker import ccs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ccs_sample_if                 samples,
  ccs_message_if                messages,
  output int                    fail_count,
  output int                    pending
);

  logic [VAL_W-1:0]      analog_prev [ANALOG_COUNT];
  logic                  level_prev [DIGITAL_COUNT];
  logic [TIME_W-1:0]     last_edge_ms [DIGITAL_COUNT];
  logic [CHAN_W-1:0]     chan_reg;
  logic [DEBOUNCE_W-1:0] debounce_reg;

  message_t pending_msgs[$];
  message_t oldest;
  int       errors = 0;

  // Work out the message caused by one accepted sample and advance the state.
  function automatic void scan_control(input sample_t s);
    logic [VAL_W-1:0]  reading;
    logic              level;
    logic [TIME_W-1:0] elapsed;
    message_t          m;
    m.message_kind = MSG_CC;
    m.channel      = chan_reg;
    m.number       = s.controller_number;
    m.value        = '0;
    if (s.input_kind == KIND_ANALOG) begin
      if (s.input_index < ANALOG_COUNT) begin
        reading = s.sample[SAMPLE_W-1:ANALOG_DROP_BITS];
        if (reading != analog_prev[s.input_index[AIDX_W-1:0]]) begin
          analog_prev[s.input_index[AIDX_W-1:0]] = reading;
          m.value = reading;
          pending_msgs.push_back(m);
        end
      end
    end else if (s.input_index < DIGITAL_COUNT) begin
      level   = s.sample[0];
      elapsed = s.now_ms - last_edge_ms[s.input_index];
      if (level != level_prev[s.input_index]) begin
        level_prev[s.input_index] = level;
        // a blocked edge still takes the new level but keeps its edge time
        if (elapsed > TIME_W'(debounce_reg)) begin
          last_edge_ms[s.input_index] = s.now_ms;
          if (s.digital_style) begin
            if (level) m.message_kind = MSG_NOTE_ON;
            else m.message_kind = MSG_NOTE_OFF;
          end
          m.value = level ? FULL_VALUE : '0;
          pending_msgs.push_back(m);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ANALOG_COUNT; i++) analog_prev[i] = '0;
      for (int i = 0; i < DIGITAL_COUNT; i++) begin
        level_prev[i]   = 1'b0;
        last_edge_ms[i] = '0;
      end
      chan_reg     = CHANNEL_RESET;
      debounce_reg = DEBOUNCE_RESET;
      pending_msgs.delete();
    end else begin
      if (messages.valid && messages.ready) begin
        if (pending_msgs.size() == 0) begin
          if (errors < 10)
            $display("unexpected message: kind %0d chan %0d num %0d val %0d",
                     messages.data.message_kind, messages.data.channel,
                     messages.data.number, messages.data.value);
          errors++;
        end else begin
          oldest = pending_msgs.pop_front();
          if (messages.data.message_kind !== oldest.message_kind ||
              messages.data.channel !== oldest.channel ||
              messages.data.number !== oldest.number ||
              messages.data.value !== oldest.value) begin
            if (errors < 10)
              $display("message mismatch: expected kind %0d chan %0d num %0d val %0d, %s",
                       oldest.message_kind, oldest.channel, oldest.number, oldest.value,
                       $sformatf("got kind %0d chan %0d num %0d val %0d",
                                 messages.data.message_kind, messages.data.channel,
                                 messages.data.number, messages.data.value));
            errors++;
          end
        end
      end
      if (samples.valid && samples.ready) scan_control(samples.data);
      if (cfg_write) begin
        case (cfg_index)
          CFG_MIDI_CHANNEL: chan_reg = cfg_data[CHAN_W-1:0];
          CFG_DEBOUNCE:     debounce_reg = cfg_data[DEBOUNCE_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    pending    <= pending_msgs.size();
  end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives scanned analog and digital control samples into the control change
// scanner under several channel and debounce settings, with random gaps and
// stalls on both channels, and reports the verdict of the message checker.
// ----------------------------------------------------------------------------
module testbench import ccs_pkg::*; ();

  localparam int PHASES = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ccs_sample_if  samples ();
  ccs_message_if messages ();

  int check_fails;
  int check_pending;

  // stimulus-side view of the stored values, used only to steer the random mix
  logic [SAMPLE_W-1:0] last_raw [ANALOG_COUNT];
  logic                last_level [DIGITAL_COUNT];
  logic [TIME_W-1:0]   clock_ms;
  int                  debounce_now;

  bit sender_idle;
  bit receiver_idle;
  bit hold_messages;

  int chan_plan [PHASES]     = '{16, 0, 31, 1, 17, 10};
  int debounce_plan [PHASES] = '{0, 65535, -1, 1, 300, 20};
  bit send_gaps [PHASES]     = '{1, 1, 0, 1, 0, 1};
  bit recv_gaps [PHASES]     = '{1, 1, 0, 0, 1, 1};

  control_change_scanner u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .samples  (samples),
    .messages (messages)
  );

  scanner_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .messages  (messages),
    .fail_count(check_fails),
    .pending   (check_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sample_t mk(logic kind, int idx, int raw, int num, logic style,
                                 logic [TIME_W-1:0] now);
    sample_t s;
    s.input_kind        = kind;
    s.input_index       = IDX_W'(idx);
    s.sample            = SAMPLE_W'(raw);
    s.controller_number = NUM_W'(num);
    s.digital_style     = style;
    s.now_ms            = now;
    return s;
  endfunction

  // Offer one request and hold it until it is taken.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = sender_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.data  <= s;
    do @(posedge clk); while (!(samples.valid && samples.ready));
    if (s.input_kind == KIND_ANALOG) begin
      if (s.input_index < ANALOG_COUNT) last_raw[s.input_index[AIDX_W-1:0]] = s.sample;
    end else if (s.input_index < DIGITAL_COUNT) begin
      last_level[s.input_index] = s.sample[0];
    end
  endtask

  // Drop valid, wait for every pending message, then let the pipeline drain.
  task automatic settle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic make_sample(output sample_t s);
    int pick;
    int idx;
    logic lvl;
    pick                = $urandom_range(0, 99);
    s.controller_number = NUM_W'($urandom_range(0, 127));
    s.digital_style     = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 49) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + TIME_W'($urandom_range(0, debounce_now / 8 + 2));
    s.now_ms = clock_ms;
    if (pick < 45) begin
      s.input_kind = KIND_ANALOG;
      if (pick < 5) idx = $urandom_range(ANALOG_COUNT, 31);
      else idx = $urandom_range(0, ANALOG_COUNT - 1);
      s.input_index = IDX_W'(idx);
      // keep the reading inside the same 7-bit step now and then
      if (idx < ANALOG_COUNT && $urandom_range(0, 3) == 0)
        s.sample = {last_raw[idx][SAMPLE_W-1:ANALOG_DROP_BITS],
                    ANALOG_DROP_BITS'($urandom_range(0, 7))};
      else
        s.sample = SAMPLE_W'($urandom_range(0, 1023));
    end else begin
      s.input_kind = KIND_DIGITAL;
      // favor a few controls so that edges land inside the hold-off window
      if ($urandom_range(0, 9) < 6) idx = $urandom_range(0, 3);
      else idx = $urandom_range(0, DIGITAL_COUNT - 1);
      s.input_index = IDX_W'(idx);
      lvl = ($urandom_range(0, 9) < 7) ? ~last_level[idx] : last_level[idx];
      s.sample = {(SAMPLE_W-1)'($urandom_range(0, 511)), lvl};
    end
  endtask

  // Message side: random stalls per request, and one long hold on demand.
  initial begin
    int gap;
    messages.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_messages) begin
        messages.ready <= 1'b0;
        repeat (80) @(posedge clk);
        hold_messages = 1'b0;
      end
      gap = receiver_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        messages.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      messages.ready <= 1'b1;
      do @(posedge clk); while (!(messages.valid && messages.ready));
    end
  end

  initial begin
    sample_t item;
    int      idx;
    int      deb;
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= CFG_MIDI_CHANNEL;
    cfg_data      <= '0;
    samples.valid <= 1'b0;
    samples.data  <= '0;
    for (int i = 0; i < ANALOG_COUNT; i++) last_raw[i] = '0;
    for (int i = 0; i < DIGITAL_COUNT; i++) last_level[i] = 1'b0;
    debounce_now  = DEBOUNCE_RESET;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_messages = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // analog: unchanged, full scale, same step, small, bit patterns, bad index
    send_sample(mk(KIND_ANALOG, 0, 0, 0, 1'b0, 0));
    send_sample(mk(KIND_ANALOG, 0, 1023, 127, 1'b1, 0));
    send_sample(mk(KIND_ANALOG, 0, 1016, 127, 1'b0, 0));
    send_sample(mk(KIND_ANALOG, 7, 8, 1, 1'b0, 0));
    send_sample(mk(KIND_ANALOG, 3, 'h2AA, 'h55, 1'b0, 32'hAAAA_AAAA));
    send_sample(mk(KIND_ANALOG, 3, 'h155, 'h2A, 1'b1, 32'h5555_5555));
    send_sample(mk(KIND_ANALOG, 8, 1023, 5, 1'b0, 0));
    send_sample(mk(KIND_ANALOG, 31, 1023, 5, 1'b1, 0));
    // digital notes: accepted, blocked, blocked edge, upper bits, boundary
    send_sample(mk(KIND_DIGITAL, 0, 1, 60, 1'b1, 100));
    send_sample(mk(KIND_DIGITAL, 0, 0, 60, 1'b1, 110));
    send_sample(mk(KIND_DIGITAL, 0, 1, 60, 1'b1, 115));
    send_sample(mk(KIND_DIGITAL, 0, 'h3FF, 60, 1'b1, 200));
    send_sample(mk(KIND_DIGITAL, 0, 'h3FE, 60, 1'b1, 120));
    send_sample(mk(KIND_DIGITAL, 0, 'h001, 60, 1'b1, 121));
    // digital control changes around the hold-off boundary
    send_sample(mk(KIND_DIGITAL, 1, 1, 0, 1'b0, 1000));
    send_sample(mk(KIND_DIGITAL, 1, 0, 0, 1'b0, 1020));
    send_sample(mk(KIND_DIGITAL, 1, 1, 0, 1'b0, 1021));
    send_sample(mk(KIND_DIGITAL, 1, 'h200, 0, 1'b0, 1042));
    // time wrapping through zero
    send_sample(mk(KIND_DIGITAL, 31, 1, 127, 1'b1, 32'hFFFF_FFF0));
    send_sample(mk(KIND_DIGITAL, 31, 0, 127, 1'b1, 32'h0000_0005));
    send_sample(mk(KIND_DIGITAL, 30, 'h155, 'h2A, 1'b0, 32'h5555_5555));
    send_sample(mk(KIND_DIGITAL, 30, 'h2AA, 'h55, 1'b1, 32'hAAAA_AAAA));
    clock_ms = 32'hAAAA_AAAA;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      deb = (debounce_plan[p] < 0) ? $urandom_range(2, 65534) : debounce_plan[p];
      cfg_write <= 1'b1;
      cfg_index <= CFG_MIDI_CHANNEL;
      cfg_data  <= CFG_DATA_W'(chan_plan[p]);
      @(posedge clk);
      cfg_index <= CFG_DEBOUNCE;
      cfg_data  <= CFG_DATA_W'(deb);
      @(posedge clk);
      cfg_write <= 1'b0;
      debounce_now  = deb;
      receiver_idle = recv_gaps[p];

      if (p == 3) begin
        // hold the message side while a back-to-back burst of changes fills the block
        sender_idle   = 1'b0;
        hold_messages = 1'b1;
        repeat (40) begin
          idx = $urandom_range(0, ANALOG_COUNT - 1);
          item = mk(KIND_ANALOG, idx, 0, $urandom_range(0, 127), 1'($urandom_range(0, 1)),
                    clock_ms);
          item.sample = last_raw[idx] ^ {NUM_W'($urandom_range(1, 127)),
                                         ANALOG_DROP_BITS'($urandom_range(0, 7))};
          send_sample(item);
        end
        settle();
      end

      sender_idle = send_gaps[p];
      repeat (100) begin
        make_sample(item);
        send_sample(item);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (check_fails == 0 && check_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ control_change_scanner.f @@
sv/ccs_pkg.sv
sv/ccs_sample_if.sv
sv/ccs_message_if.sv
sv/ccs_scan_core.sv
sv/ccs_msg_reg.sv
sv/control_change_scanner.sv
verif/scanner_checker.sv
verif/testbench.sv
